FILE: sv/jssd_pkg.sv
// joystick servo slew driver: shared types, register codes and constants
// used by jssd_lane, jssd_merge and joystick_servo_slew_driver_top
// no dependencies
`default_nettype none

package jssd_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 15;

  localparam int unsigned DEAD_BAND_W = 11;
  localparam int unsigned CENTER_W    = 12;
  localparam int unsigned STEP_W      = 8;
  localparam int unsigned PULSE_W     = 15;
  localparam int unsigned ANGLE_W     = 8;
  localparam int unsigned DUTY_W      = 16;

  localparam int unsigned FULL_ANGLE  = 180;
  localparam int unsigned ANGLE_RESET = 90;

  localparam logic [DEAD_BAND_W-1:0] DEAD_BAND_RESET = 11'd150;
  localparam logic [CENTER_W-1:0]    CENTER_RESET    = 12'd2048;
  localparam logic [STEP_W-1:0]      STEP_RESET      = 8'd3;
  localparam logic [PULSE_W-1:0]     PULSE_MIN_RESET = 15'd500;
  localparam logic [PULSE_W-1:0]     PULSE_MAX_RESET = 15'd2500;

  // exact floor(x / 180) for x below 2^(PULSE_W + ANGLE_W)
  localparam int unsigned     DIV180_SHIFT  = PULSE_W + 2 * ANGLE_W;
  localparam longint unsigned DIV180_MULT   =
    ((64'd1 << DIV180_SHIFT) + 64'(FULL_ANGLE) - 64'd1) / 64'(FULL_ANGLE);
  localparam int unsigned     DIV180_MULT_W = $clog2(DIV180_MULT + 64'd1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEAD_BAND    = 3'd0,
    REG_STICK_CENTER = 3'd1,
    REG_SLEW_STEP    = 3'd2,
    REG_PULSE_MIN    = 3'd3,
    REG_PULSE_MAX    = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AIM,
    ST_SLEW,
    ST_SPAN,
    ST_PULSE,
    ST_EST,
    ST_CHECK,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [DEAD_BAND_W-1:0] dead_band;
    logic [CENTER_W-1:0]    stick_center;
    logic [STEP_W-1:0]      slew_step;
    logic [PULSE_W-1:0]     pulse_min_us;
    logic [PULSE_W-1:0]     pulse_max_us;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic aim;
    logic slew;
    logic span;
    logic pulse;
    logic est;
    logic check;
  } lane_ctrl_t;

endpackage

`default_nettype wire

FILE: sv/jssd_lane.sv
// one axis lane: dead band test, target scaling, slew limiting and
// angle to duty conversion, one step per enable from the control struct
// depends on jssd_pkg
`default_nettype none

module jssd_lane #(
  parameter int unsigned SAMPLE_BITS = 12,
  parameter int unsigned DUTY_BITS   = 16,
  parameter int unsigned PERIOD_US   = 20000
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  jssd_pkg::lane_ctrl_t           ctrl_i,
  input  jssd_pkg::cfg_t                 cfg_i,
  input  logic [SAMPLE_BITS-1:0]         sample_i,
  output logic [jssd_pkg::ANGLE_W-1:0]   angle_o,
  output logic [jssd_pkg::DUTY_W-1:0]    duty_o
);
  import jssd_pkg::*;

  localparam int unsigned SAMPLE_MAX = (1 << SAMPLE_BITS) - 1;
  localparam int unsigned PROD_W     = SAMPLE_BITS + ANGLE_W;
  localparam int unsigned DIST_W     =
    ((SAMPLE_BITS > CENTER_W) ? SAMPLE_BITS : CENTER_W) + 1;
  localparam int unsigned X_W        = PULSE_W + ANGLE_W;
  localparam int unsigned XM_W       = X_W + DIV180_MULT_W;
  localparam longint unsigned DUTY_FULL = (64'd1 << DUTY_BITS) - 64'd1;
  localparam int unsigned NUM_W      = PULSE_W + DUTY_BITS;
  localparam longint unsigned KF     = (DUTY_FULL << PULSE_W) / 64'(PERIOD_US);
  localparam int unsigned KF_W       = $clog2(KF + 64'd1);
  localparam int unsigned EP_W       = PULSE_W + KF_W;

  logic [PROD_W-1:0]  prod_d, prod_q;
  logic               hit_d, hit_q;
  logic [ANGLE_W-1:0] target_d, target_q;
  logic [ANGLE_W-1:0] angle_d, angle_q;
  logic [X_W-1:0]     x_d, x_q;
  logic [PULSE_W-1:0] us_d, us_q;
  logic [KF_W-1:0]    est_d, est_q;
  logic [NUM_W-1:0]   num_d, num_q;
  logic [NUM_W-1:0]   chk_d, chk_q;

  logic [DIST_W-1:0]  s_ext, c_ext, offset;
  logic [ANGLE_W-1:0] q0, aim_val;
  logic [PROD_W-1:0]  back, rem;
  logic [ANGLE_W-1:0] diff;
  logic [PULSE_W-1:0] span;
  logic [XM_W-1:0]    xm;
  logic [EP_W-1:0]    est_prod;
  logic [NUM_W-1:0]   rem2, quo, sat;

  // dead band test and sample scaling product
  assign s_ext  = DIST_W'(sample_i);
  assign c_ext  = DIST_W'(cfg_i.stick_center);
  assign offset = (s_ext >= c_ext) ? (s_ext - c_ext) : (c_ext - s_ext);
  assign hit_d  = offset > DIST_W'(cfg_i.dead_band);
  assign prod_d = PROD_W'(sample_i) * PROD_W'(FULL_ANGLE);

  // divide by 2^n - 1: shift estimate plus one correction
  assign q0       = prod_q[PROD_W-1:SAMPLE_BITS];
  assign back     = {q0, {SAMPLE_BITS{1'b0}}} - PROD_W'(q0);
  assign rem      = prod_q - back;
  assign aim_val  = q0 + ANGLE_W'(rem >= PROD_W'(SAMPLE_MAX));
  assign target_d = hit_q ? aim_val : target_q;

  always_comb begin
    diff    = '0;
    angle_d = angle_q;
    if (angle_q < target_q) begin
      diff    = target_q - angle_q;
      angle_d = (diff <= cfg_i.slew_step) ? target_q : angle_q + cfg_i.slew_step;
    end else if (angle_q > target_q) begin
      diff    = angle_q - target_q;
      angle_d = (diff <= cfg_i.slew_step) ? target_q : angle_q - cfg_i.slew_step;
    end
  end

  assign span = (cfg_i.pulse_max_us >= cfg_i.pulse_min_us) ?
                (cfg_i.pulse_max_us - cfg_i.pulse_min_us) : '0;
  assign x_d  = X_W'(span) * X_W'(angle_q);

  assign xm   = XM_W'(x_q) * XM_W'(DIV180_MULT);
  assign us_d = cfg_i.pulse_min_us + xm[DIV180_SHIFT +: PULSE_W];

  // duty = us * full scale / PERIOD_US via reciprocal estimate and one correction
  assign est_prod = EP_W'(us_q) * EP_W'(KF);
  assign est_d    = est_prod[EP_W-1:PULSE_W];
  assign num_d    = NUM_W'(us_q) * NUM_W'(DUTY_FULL);
  assign chk_d    = NUM_W'(est_q) * NUM_W'(PERIOD_US);

  assign rem2 = num_q - chk_q;
  assign quo  = NUM_W'(est_q) + NUM_W'(rem2 >= NUM_W'(PERIOD_US));
  assign sat  = (quo > NUM_W'(DUTY_FULL)) ? NUM_W'(DUTY_FULL) : quo;

  assign duty_o  = sat[DUTY_W-1:0];
  assign angle_o = angle_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= ANGLE_W'(ANGLE_RESET);
      angle_q  <= ANGLE_W'(ANGLE_RESET);
    end else begin
      if (ctrl_i.aim) begin
        target_q <= target_d;
      end
      if (ctrl_i.slew) begin
        angle_q <= angle_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      prod_q <= prod_d;
      hit_q  <= hit_d;
    end
    if (ctrl_i.span) begin
      x_q <= x_d;
    end
    if (ctrl_i.pulse) begin
      us_q <= us_d;
    end
    if (ctrl_i.est) begin
      est_q <= est_d;
      num_q <= num_d;
    end
    if (ctrl_i.check) begin
      chk_q <= chk_d;
    end
  end

endmodule

`default_nettype wire

FILE: sv/jssd_merge.sv
// merge stage: button edge detection, channel pair toggle and the output
// register that combines both lane results into one transaction
// depends on jssd_pkg
`default_nettype none

module jssd_merge (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic                          button_i,
  input  logic                          load_i,
  input  logic [jssd_pkg::DUTY_W-1:0]   duty_x_i,
  input  logic [jssd_pkg::DUTY_W-1:0]   duty_y_i,
  input  logic [jssd_pkg::ANGLE_W-1:0]  angle_x_i,
  input  logic [jssd_pkg::ANGLE_W-1:0]  angle_y_i,
  input  logic                          out_ready_i,
  output logic                          free_o,
  output logic                          out_valid_o,
  output logic [jssd_pkg::DUTY_W-1:0]   duty_x_o,
  output logic [jssd_pkg::DUTY_W-1:0]   duty_y_o,
  output logic                          pair_select_o,
  output logic [jssd_pkg::ANGLE_W-1:0]  angle_x_now_o,
  output logic [jssd_pkg::ANGLE_W-1:0]  angle_y_now_o
);
  import jssd_pkg::*;

  logic               prev_q, prev_d;
  logic               pair_q, pair_d;
  logic               valid_q, valid_d;
  logic [DUTY_W-1:0]  duty_x_q, duty_y_q;
  logic [ANGLE_W-1:0] angle_x_q, angle_y_q;
  logic               sel_q;

  // falling edge of the active low button
  assign pair_d  = (accept_i && !button_i && prev_q) ? !pair_q : pair_q;
  assign prev_d  = accept_i ? button_i : prev_q;
  assign free_o  = !valid_q || out_ready_i;
  assign valid_d = load_i ? 1'b1 : (out_ready_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= 1'b1;
      pair_q  <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      prev_q  <= prev_d;
      pair_q  <= pair_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      duty_x_q  <= duty_x_i;
      duty_y_q  <= duty_y_i;
      angle_x_q <= angle_x_i;
      angle_y_q <= angle_y_i;
      sel_q     <= pair_q;
    end
  end

  assign out_valid_o   = valid_q;
  assign duty_x_o      = duty_x_q;
  assign duty_y_o      = duty_y_q;
  assign pair_select_o = sel_q;
  assign angle_x_now_o = angle_x_q;
  assign angle_y_now_o = angle_y_q;

endmodule

`default_nettype wire

FILE: sv/joystick_servo_slew_driver_top.sv
// top level of the joystick servo slew driver: configuration registers,
// step sequencer, X and Y lanes and the merge stage
// depends on jssd_pkg, jssd_lane, jssd_merge
`default_nettype none

// One input transaction carries an X and Y joystick sample and the button
// level; one output transaction returns both servo duties, the selected
// channel pair and the two angles after the tick. Both axes run in their own
// lane in parallel, stepped by one shared sequencer through dead band test,
// target scaling, slew, pulse width and duty steps. After acceptance the
// sequencer runs through its seven steps, AIM, SLEW, SPAN, PULSE, EST, CHECK
// and DONE, before it can accept the next item; a stalled output holds the
// sequencer in its last step. A new item is accepted while the previous
// result still waits in the output register.
module joystick_servo_slew_driver_top #(
  parameter int unsigned SAMPLE_BITS = 12,
  parameter int unsigned DUTY_BITS   = 16,
  parameter int unsigned PERIOD_US   = 20000
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [jssd_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [jssd_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [SAMPLE_BITS-1:0]           x_sample_i,
  input  logic [SAMPLE_BITS-1:0]           y_sample_i,
  input  logic                             button_level_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [jssd_pkg::DUTY_W-1:0]      duty_x_o,
  output logic [jssd_pkg::DUTY_W-1:0]      duty_y_o,
  output logic                             pair_select_o,
  output logic [jssd_pkg::ANGLE_W-1:0]     angle_x_now_o,
  output logic [jssd_pkg::ANGLE_W-1:0]     angle_y_now_o
);
  import jssd_pkg::*;

  cfg_t       cfg_q, cfg_d;
  state_e     state_q, state_d;
  lane_ctrl_t ctrl;
  logic       accept;
  logic       load_out;
  logic       out_free;

  logic [DUTY_W-1:0]  duty_x, duty_y;
  logic [ANGLE_W-1:0] angle_x, angle_y;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        REG_DEAD_BAND:    cfg_d.dead_band    = cfg_data_i[DEAD_BAND_W-1:0];
        REG_STICK_CENTER: cfg_d.stick_center = cfg_data_i[CENTER_W-1:0];
        REG_SLEW_STEP:    cfg_d.slew_step    = cfg_data_i[STEP_W-1:0];
        REG_PULSE_MIN:    cfg_d.pulse_min_us = cfg_data_i[PULSE_W-1:0];
        REG_PULSE_MAX:    cfg_d.pulse_max_us = cfg_data_i[PULSE_W-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dead_band    <= DEAD_BAND_RESET;
      cfg_q.stick_center <= CENTER_RESET;
      cfg_q.slew_step    <= STEP_RESET;
      cfg_q.pulse_min_us <= PULSE_MIN_RESET;
      cfg_q.pulse_max_us <= PULSE_MAX_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  state_d = in_valid_i ? ST_AIM : ST_IDLE;
      ST_AIM:   state_d = ST_SLEW;
      ST_SLEW:  state_d = ST_SPAN;
      ST_SPAN:  state_d = ST_PULSE;
      ST_PULSE: state_d = ST_EST;
      ST_EST:   state_d = ST_CHECK;
      ST_CHECK: state_d = ST_DONE;
      ST_DONE:  state_d = out_free ? ST_IDLE : ST_DONE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    ctrl       = '0;
    in_ready_o = 1'b0;
    load_out   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        ctrl.load  = in_valid_i;
      end
      ST_AIM:   ctrl.aim   = 1'b1;
      ST_SLEW:  ctrl.slew  = 1'b1;
      ST_SPAN:  ctrl.span  = 1'b1;
      ST_PULSE: ctrl.pulse = 1'b1;
      ST_EST:   ctrl.est   = 1'b1;
      ST_CHECK: ctrl.check = 1'b1;
      ST_DONE:  load_out   = out_free;
      default:  ctrl       = '0;
    endcase
  end

  assign accept = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  jssd_lane #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .DUTY_BITS   (DUTY_BITS),
    .PERIOD_US   (PERIOD_US)
  ) u_lane_x (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .cfg_i    (cfg_q),
    .sample_i (x_sample_i),
    .angle_o  (angle_x),
    .duty_o   (duty_x)
  );

  jssd_lane #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .DUTY_BITS   (DUTY_BITS),
    .PERIOD_US   (PERIOD_US)
  ) u_lane_y (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .cfg_i    (cfg_q),
    .sample_i (y_sample_i),
    .angle_o  (angle_y),
    .duty_o   (duty_y)
  );

  jssd_merge u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .button_i      (button_level_i),
    .load_i        (load_out),
    .duty_x_i      (duty_x),
    .duty_y_i      (duty_y),
    .angle_x_i     (angle_x),
    .angle_y_i     (angle_y),
    .out_ready_i   (out_ready_i),
    .free_o        (out_free),
    .out_valid_o   (out_valid_o),
    .duty_x_o      (duty_x_o),
    .duty_y_o      (duty_y_o),
    .pair_select_o (pair_select_o),
    .angle_x_now_o (angle_x_now_o),
    .angle_y_now_o (angle_y_now_o)
  );

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == ST_AIM)
    else $error("accepted transaction did not start the sequencer");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == ST_DONE)
    else $error("result appeared without a finished sequence");

  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (angle_x_now_o <= ANGLE_W'(FULL_ANGLE)) &&
                    (angle_y_now_o <= ANGLE_W'(FULL_ANGLE)))
    else $error("angle out of range");

endmodule

`default_nettype wire
